// ----- sv/jbq_pkg.sv -----
// ----------------------------------------------------------------------------
// jbq_pkg
// shared types and constants for the joystick button qualifier
// ----------------------------------------------------------------------------
package jbq_pkg;

  localparam int SAMPLE_W  = 12;
  localparam int COUNT_W   = 4;
  localparam int DEBOUNCE_W = 16;
  localparam int TIME_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // axis value, two bit two's complement
  typedef logic signed [1:0] axis_t;
  localparam axis_t AXIS_ZERO = 2'sb00;
  localparam axis_t AXIS_POS  = 2'sb01;
  localparam axis_t AXIS_NEG  = 2'sb11;

  typedef enum logic [2:0] {
    DIR_CENTRE = 3'd0,
    DIR_NORTH  = 3'd1,
    DIR_EAST   = 3'd2,
    DIR_SOUTH  = 3'd3,
    DIR_WEST   = 3'd4
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REST_X        = 3'd0,
    CFG_REST_Y        = 3'd1,
    CFG_DEADZONE      = 3'd2,
    CFG_CONFIRM_READS = 3'd3,
    CFG_DEBOUNCE_MS   = 3'd4
  } cfg_idx_t;

  localparam logic [SAMPLE_W-1:0]   CENTER_RST   = 12'd2048;
  localparam logic [SAMPLE_W-1:0]   DEADZONE_RST = 12'd650;
  localparam logic [COUNT_W-1:0]    CONFIRM_RST  = 4'd3;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 16'd35;

endpackage

// ----- sv/jbq_axis.sv -----
// ----------------------------------------------------------------------------
// jbq_axis
// deadzone classify and repeat-confirm qualify for one axis
// ----------------------------------------------------------------------------
module jbq_axis (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          invert,
  input  logic [jbq_pkg::SAMPLE_W-1:0]  sample,
  input  logic [jbq_pkg::SAMPLE_W-1:0]  center,
  input  logic [jbq_pkg::SAMPLE_W-1:0]  deadzone,
  input  logic [jbq_pkg::COUNT_W-1:0]   confirm_reads,
  output jbq_pkg::axis_t                settled
);
  import jbq_pkg::*;

  axis_t                settled_r, settled_nxt;
  axis_t                pending_r, pending_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [COUNT_W-1:0]   count_inc;
  axis_t                pend_tmp;
  axis_t                raw;
  logic signed [SAMPLE_W+1:0] offset;
  logic signed [SAMPLE_W+1:0] dz;

  // offset from centre, y is inverted
  always_comb begin
    dz = $signed({2'b00, deadzone});
    if (invert) begin
      offset = $signed({2'b00, center}) - $signed({2'b00, sample});
    end else begin
      offset = $signed({2'b00, sample}) - $signed({2'b00, center});
    end
    if (offset > dz) begin
      raw = AXIS_POS;
    end else if (offset < -dz) begin
      raw = AXIS_NEG;
    end else begin
      raw = AXIS_ZERO;
    end
  end

  always_comb begin
    settled_nxt = settled_r;
    pending_nxt = pending_r;
    count_nxt   = count_r;
    pend_tmp    = pending_r;
    count_inc   = count_r;
    if (raw == settled_r) begin
      pending_nxt = raw;
      count_nxt   = '0;
    end else if (raw == AXIS_ZERO) begin
      settled_nxt = AXIS_ZERO;
      pending_nxt = AXIS_ZERO;
      count_nxt   = '0;
    end else begin
      if (raw == pending_r) begin
        // saturate at confirm_reads
        if (count_r < confirm_reads) begin
          count_inc = count_r + 1'b1;
        end
      end else begin
        pend_tmp  = raw;
        count_inc = COUNT_W'(1);
      end
      pending_nxt = pend_tmp;
      if (count_inc >= confirm_reads) begin
        settled_nxt = pend_tmp;
        count_nxt   = '0;
      end else begin
        count_nxt   = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settled_r <= AXIS_ZERO;
      pending_r <= AXIS_ZERO;
      count_r   <= '0;
    end else if (en) begin
      settled_r <= settled_nxt;
      pending_r <= pending_nxt;
      count_r   <= count_nxt;
    end
  end

  assign settled = settled_nxt;

endmodule

// ----- sv/jbq_dir.sv -----
// ----------------------------------------------------------------------------
// jbq_dir
// four-way direction map with diagonal tie-break memory
// ----------------------------------------------------------------------------
module jbq_dir (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  jbq_pkg::axis_t move_x,
  input  jbq_pkg::axis_t move_y,
  output jbq_pkg::dir_t  direction
);
  import jbq_pkg::*;

  dir_t last_r, last_nxt;
  dir_t dir;

  always_comb begin
    last_nxt = last_r;
    dir      = last_r;
    if (move_x == AXIS_ZERO && move_y == AXIS_ZERO) begin
      last_nxt = DIR_CENTRE;
      dir      = DIR_CENTRE;
    end else if (move_x != AXIS_ZERO && move_y != AXIS_ZERO) begin
      // diagonal: memory unchanged
      if (last_r == DIR_EAST || last_r == DIR_WEST) begin
        dir = (move_x == AXIS_POS) ? DIR_EAST : DIR_WEST;
      end else begin
        dir = (move_y == AXIS_POS) ? DIR_SOUTH : DIR_NORTH;
      end
    end else begin
      if (move_x == AXIS_POS) begin
        last_nxt = DIR_EAST;
      end else if (move_x == AXIS_NEG) begin
        last_nxt = DIR_WEST;
      end else if (move_y == AXIS_POS) begin
        last_nxt = DIR_SOUTH;
      end else begin
        last_nxt = DIR_NORTH;
      end
      dir = last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= DIR_CENTRE;
    end else if (en) begin
      last_r <= last_nxt;
    end
  end

  assign direction = dir;

endmodule

// ----- sv/jbq_button.sv -----
// ----------------------------------------------------------------------------
// jbq_button
// time-stamp based button debounce with press edge flag
// ----------------------------------------------------------------------------
module jbq_button (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           level,
  input  logic [jbq_pkg::TIME_W-1:0]     time_ms,
  input  logic [jbq_pkg::DEBOUNCE_W-1:0] debounce_ms,
  output logic                           held,
  output logic                           pressed
);
  import jbq_pkg::*;

  logic              stable_r, stable_nxt;
  logic [TIME_W-1:0] last_change_r, last_change_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              take;

  // elapsed time wraps modulo 2^32
  assign elapsed = time_ms - last_change_r;
  assign take    = (level != stable_r) &&
                   (elapsed >= {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_ms});

  always_comb begin
    stable_nxt      = stable_r;
    last_change_nxt = last_change_r;
    if (take) begin
      stable_nxt      = level;
      last_change_nxt = time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r      <= 1'b0;
      last_change_r <= '0;
    end else if (en) begin
      stable_r      <= stable_nxt;
      last_change_r <= last_change_nxt;
    end
  end

  assign held    = stable_nxt;
  assign pressed = take & level;

endmodule

// ----- sv/joystick_button_qualifier.sv -----
// ----------------------------------------------------------------------------
// joystick_button_qualifier
// joystick deadzone, axis confirm, 4-way direction and button debounce
// ----------------------------------------------------------------------------
// Each input word is one frame (x and y samples, button level, ms time stamp)
// and yields exactly one result word. A frame is captured in an input
// register, qualified by short combinational logic and written to the result
// register, which drives out_valid, so one word per cycle is sustained while
// out_ready stays high. The frame state (axis confirm counters, direction
// memory, debounce time stamp) is updated in the same cycle the word moves
// into the result register. Throughput drops only when the result register
// is held by out_ready low. Configuration registers
// (index 0 rest_x, 1 rest_y, 2 deadzone, 3 confirm_reads,
// 4 debounce_ms) are written through the cfg port, always ready, and should
// be changed only while no word is in flight; other indexes are ignored.
module joystick_button_qualifier (
  input  logic                           clk,
  input  logic                           rst_n,
  // input frame channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [jbq_pkg::SAMPLE_W-1:0]   in_x_sample,
  input  logic [jbq_pkg::SAMPLE_W-1:0]   in_y_sample,
  input  logic                           in_button_level,
  input  logic [jbq_pkg::TIME_W-1:0]     in_time_ms,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [1:0]              out_move_x,
  output logic signed [1:0]              out_move_y,
  output logic [2:0]                     out_direction,
  output logic                           out_button_held,
  output logic                           out_button_pressed,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jbq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jbq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jbq_pkg::*;

  // configuration registers
  logic [SAMPLE_W-1:0]   rest_x_r;
  logic [SAMPLE_W-1:0]   rest_y_r;
  logic [SAMPLE_W-1:0]   deadzone_r;
  logic [COUNT_W-1:0]    confirm_reads_r;
  logic [DEBOUNCE_W-1:0] debounce_ms_r;

  // input register
  logic                  s1_valid_r;
  logic [SAMPLE_W-1:0]   x_r;
  logic [SAMPLE_W-1:0]   y_r;
  logic                  level_r;
  logic [TIME_W-1:0]     time_r;

  // result register
  logic                  out_valid_r;
  axis_t                 move_x_r;
  axis_t                 move_y_r;
  dir_t                  direction_r;
  logic                  held_r;
  logic                  pressed_r;

  logic                  advance;
  axis_t                 mx;
  axis_t                 my;
  dir_t                  dir;
  logic                  held;
  logic                  pressed;

  // word moves from input register to result register
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_x_r        <= CENTER_RST;
      rest_y_r        <= CENTER_RST;
      deadzone_r      <= DEADZONE_RST;
      confirm_reads_r <= CONFIRM_RST;
      debounce_ms_r   <= DEBOUNCE_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REST_X:        rest_x_r        <= cfg_data[SAMPLE_W-1:0];
        CFG_REST_Y:        rest_y_r        <= cfg_data[SAMPLE_W-1:0];
        CFG_DEADZONE:      deadzone_r      <= cfg_data[SAMPLE_W-1:0];
        CFG_CONFIRM_READS: confirm_reads_r <= cfg_data[COUNT_W-1:0];
        CFG_DEBOUNCE_MS:   debounce_ms_r   <= cfg_data[DEBOUNCE_W-1:0];
        default: ;
      endcase
    end
  end

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r     <= in_x_sample;
      y_r     <= in_y_sample;
      level_r <= in_button_level;
      time_r  <= in_time_ms;
    end
  end

  // x axis, offset sample minus centre
  jbq_axis u_axis_x (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (advance),
    .invert        (1'b0),
    .sample        (x_r),
    .center        (rest_x_r),
    .deadzone      (deadzone_r),
    .confirm_reads (confirm_reads_r),
    .settled       (mx)
  );

  // y axis, inverted: centre minus sample
  jbq_axis u_axis_y (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (advance),
    .invert        (1'b1),
    .sample        (y_r),
    .center        (rest_y_r),
    .deadzone      (deadzone_r),
    .confirm_reads (confirm_reads_r),
    .settled       (my)
  );

  jbq_dir u_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .move_x    (mx),
    .move_y    (my),
    .direction (dir)
  );

  jbq_button u_button (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .level       (level_r),
    .time_ms     (time_r),
    .debounce_ms (debounce_ms_r),
    .held        (held),
    .pressed     (pressed)
  );

  // result register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      move_x_r    <= mx;
      move_y_r    <= my;
      direction_r <= dir;
      held_r      <= held;
      pressed_r   <= pressed;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_move_x         = move_x_r;
  assign out_move_y         = move_y_r;
  assign out_direction      = direction_r;
  assign out_button_held    = held_r;
  assign out_button_pressed = pressed_r;

endmodule

// ----- sim/tb_joystick_button_qualifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joystick_button_qualifier
// self-checking bench for the joystick deadzone and button debounce block:
// frames go in over a valid/ready channel and each result word is checked
// field by field against an in-bench model of the axis confirm logic, the
// 4-way direction memory and the button debounce timer
// ----------------------------------------------------------------------------
module tb_joystick_button_qualifier;
  import jbq_pkg::*;

  // longest stretch with no word moving on any channel before we give up
  localparam int WATCHDOG_LIMIT = 2000;
  // receiver hold-off used to back the block up into its input
  localparam int LONG_HOLD      = 300;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [SAMPLE_W-1:0]   in_x_sample;
  logic [SAMPLE_W-1:0]   in_y_sample;
  logic                  in_button_level;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic signed [1:0]     out_move_x;
  logic signed [1:0]     out_move_y;
  logic [2:0]            out_direction;
  logic                  out_button_held;
  logic                  out_button_pressed;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  joystick_button_qualifier i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_x_sample        (in_x_sample),
    .in_y_sample        (in_y_sample),
    .in_button_level    (in_button_level),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_move_x         (out_move_x),
    .out_move_y         (out_move_y),
    .out_direction      (out_direction),
    .out_button_held    (out_button_held),
    .out_button_pressed (out_button_pressed),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // one qualified frame as the block should report it
  typedef struct {
    axis_t move_x;
    axis_t move_y;
    dir_t  direction;
    logic  held;
    logic  pressed;
  } joy_result_t;

  joy_result_t joy_results_due[$];

  // model copy of the registers
  logic [SAMPLE_W-1:0]   ctr_x;
  logic [SAMPLE_W-1:0]   ctr_y;
  logic [SAMPLE_W-1:0]   dead_band;
  logic [COUNT_W-1:0]    confirm_need;
  logic [DEBOUNCE_W-1:0] debounce_len;

  // model copy of the frame state, axis 0 is x and axis 1 is y
  int                    axis_settled [2];
  int                    axis_pending [2];
  logic [COUNT_W-1:0]    axis_count   [2];
  dir_t                  heading;
  logic                  btn_stable;
  logic [TIME_W-1:0]     btn_changed_at;

  int error_count;
  int results_seen;

  // stimulus state
  logic [TIME_W-1:0] now_ms;
  logic              btn_target;
  bit                input_gaps;
  int                burst_left;

  // receiver state, driven by its own process
  bit rx_stalls;
  int rx_hold_left;
  bit rx_ready_phase;
  int rx_run_left;

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // model of the block
  // --------------------------------------------------------------------------
  task automatic reset_model();
    ctr_x          = CENTER_RST;
    ctr_y          = CENTER_RST;
    dead_band      = DEADZONE_RST;
    confirm_need   = CONFIRM_RST;
    debounce_len   = DEBOUNCE_RST;
    for (int a = 0; a < 2; a++) begin
      axis_settled[a] = 0;
      axis_pending[a] = 0;
      axis_count[a]   = '0;
    end
    heading        = DIR_CENTRE;
    btn_stable     = 1'b0;
    btn_changed_at = '0;
  endtask

  // only the low bits of the data word land in each register narrower than it
  task automatic write_model_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_REST_X:        ctr_x        = data[SAMPLE_W-1:0];
      CFG_REST_Y:        ctr_y        = data[SAMPLE_W-1:0];
      CFG_DEADZONE:      dead_band    = data[SAMPLE_W-1:0];
      CFG_CONFIRM_READS: confirm_need = data[COUNT_W-1:0];
      CFG_DEBOUNCE_MS:   debounce_len = data;
      default: ;
    endcase
  endtask

  // strict compare against the deadzone on both sides
  function automatic int deflection(int offset);
    int d;
    d = int'(dead_band);
    if (offset > d) begin
      return 1;
    end
    if (offset < -d) begin
      return -1;
    end
    return 0;
  endfunction

  // accept a raw axis reading after enough equal nonzero reads, or at once
  // when it falls back to zero
  function automatic int confirm_axis(int a, int raw);
    if (raw == axis_settled[a]) begin
      axis_pending[a] = raw;
      axis_count[a]   = '0;
      return axis_settled[a];
    end
    if (raw == 0) begin
      axis_settled[a] = 0;
      axis_pending[a] = 0;
      axis_count[a]   = '0;
      return 0;
    end
    if (raw == axis_pending[a]) begin
      if (axis_count[a] < confirm_need) begin
        axis_count[a] = axis_count[a] + 1'b1;
      end
    end else begin
      axis_pending[a] = raw;
      axis_count[a]   = 4'd1;
    end
    if (axis_count[a] >= confirm_need) begin
      axis_settled[a] = axis_pending[a];
      axis_count[a]   = '0;
    end
    return axis_settled[a];
  endfunction

  // on a diagonal the heading is kept: horizontal wins only after east/west
  function automatic dir_t direction_of(int mx, int my);
    if (mx == 0 && my == 0) begin
      heading = DIR_CENTRE;
      return DIR_CENTRE;
    end
    if (mx != 0 && my != 0) begin
      if (heading == DIR_EAST || heading == DIR_WEST) begin
        return (mx > 0) ? DIR_EAST : DIR_WEST;
      end
      return (my > 0) ? DIR_SOUTH : DIR_NORTH;
    end
    if (mx > 0) begin
      heading = DIR_EAST;
    end else if (mx < 0) begin
      heading = DIR_WEST;
    end else if (my > 0) begin
      heading = DIR_SOUTH;
    end else begin
      heading = DIR_NORTH;
    end
    return heading;
  endfunction

  function automatic joy_result_t qualify_frame(logic [SAMPLE_W-1:0] xs,
                                                logic [SAMPLE_W-1:0] ys,
                                                logic lvl, logic [TIME_W-1:0] stamp);
    int          mx;
    int          my;
    logic [TIME_W-1:0] elapsed;
    joy_result_t r;
    // y is inverted so that pushing up reads negative
    mx = confirm_axis(0, deflection(int'(xs) - int'(ctr_x)));
    my = confirm_axis(1, deflection(int'(ctr_y) - int'(ys)));
    r.move_x    = mx[1:0];
    r.move_y    = my[1:0];
    r.direction = direction_of(mx, my);
    r.pressed   = 1'b0;
    // elapsed time wraps with the tick counter
    elapsed = stamp - btn_changed_at;
    if (lvl != btn_stable && elapsed >= {16'd0, debounce_len}) begin
      btn_changed_at = stamp;
      btn_stable     = lvl;
      r.pressed      = lvl;
    end
    r.held = btn_stable;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    error_count++;
    $display("result word %0d: %s", results_seen, what);
  endtask

  // everything is sampled right at the rising edge, before the block updates;
  // register writes and input words feed the model, result words are checked
  always @(posedge clk) begin
    joy_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        write_model_reg(cfg_index, cfg_data);
      end
      if (in_valid && in_ready) begin
        joy_results_due.push_back(qualify_frame(in_x_sample, in_y_sample,
                                                in_button_level, in_time_ms));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (joy_results_due.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = joy_results_due.pop_front();
          if (out_move_x !== want.move_x) begin
            report_mismatch($sformatf("move_x got %0d expected %0d", out_move_x, want.move_x));
          end
          if (out_move_y !== want.move_y) begin
            report_mismatch($sformatf("move_y got %0d expected %0d", out_move_y, want.move_y));
          end
          if (out_direction !== want.direction) begin
            report_mismatch($sformatf("direction got %0d expected %0d",
                                      out_direction, want.direction));
          end
          if (out_button_held !== want.held) begin
            report_mismatch($sformatf("button_held got %b expected %b",
                                      out_button_held, want.held));
          end
          if (out_button_pressed !== want.pressed) begin
            report_mismatch($sformatf("button_pressed got %b expected %b",
                                      out_button_pressed, want.pressed));
          end
        end
      end
    end
  end

  // watchdog: any word moving on any channel resets the count
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("tb_joystick_button_qualifier: errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: free running, long hold-off on request, else random runs of
  // ready and stall when stalls are enabled
  // --------------------------------------------------------------------------
  initial begin
    out_ready      = 1'b0;
    rx_ready_phase = 1'b0;
    rx_run_left    = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_left > 0) begin
        out_ready = 1'b0;
        rx_hold_left--;
      end else if (!rx_stalls) begin
        out_ready = 1'b1;
      end else begin
        if (rx_run_left == 0) begin
          rx_ready_phase = !rx_ready_phase;
          rx_run_left    = rx_ready_phase ? $urandom_range(1, 10) : $urandom_range(1, 4);
        end
        out_ready = rx_ready_phase;
        rx_run_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender side
  // --------------------------------------------------------------------------

  // present one word at the falling edge and hold it until it is taken
  task automatic offer_frame(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                             logic lvl, logic [TIME_W-1:0] stamp);
    @(negedge clk);
    in_valid        = 1'b1;
    in_x_sample     = xs;
    in_y_sample     = ys;
    in_button_level = lvl;
    in_time_ms      = stamp;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic pause_input(int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // bursts of words with random gaps in between when gaps are on
  task automatic send_frame(logic [SAMPLE_W-1:0] xs, logic [SAMPLE_W-1:0] ys,
                            logic lvl, logic [TIME_W-1:0] stamp);
    if (input_gaps && burst_left == 0) begin
      pause_input($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) begin
      burst_left--;
    end
    offer_frame(xs, ys, lvl, stamp);
  endtask

  // stop sending and let every word in flight come out
  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (joy_results_due.size() != 0) begin
      @(negedge clk);
    end
    // let the two-stage pipe go quiet
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // upper data bits carry junk, the block must ignore them
  task automatic set_registers(logic [SAMPLE_W-1:0] cxv, logic [SAMPLE_W-1:0] cyv,
                               logic [SAMPLE_W-1:0] dzv, logic [COUNT_W-1:0] crv,
                               logic [DEBOUNCE_W-1:0] dbv);
    logic [3:0]  junk4;
    logic [11:0] junk12;
    junk4  = 4'($urandom);
    junk12 = 12'($urandom);
    settle();
    write_reg(CFG_REST_X, {junk4, cxv});
    junk4 = 4'($urandom);
    write_reg(CFG_REST_Y, {junk4, cyv});
    junk4 = 4'($urandom);
    write_reg(CFG_DEADZONE, {junk4, dzv});
    write_reg(CFG_CONFIRM_READS, {junk12, crv});
    write_reg(CFG_DEBOUNCE_MS, dbv);
  endtask

  // a sample that lands on the wanted side of the deadzone around ctr,
  // often right on the boundary; random when that side cannot be reached
  function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] ctr, int side);
    int c;
    int d;
    int lo;
    int hi;
    c = int'(ctr);
    d = int'(dead_band);
    case (side)
      1: begin
        lo = c + d + 1;
        if (lo > 4095) begin
          return SAMPLE_W'($urandom);
        end
        return SAMPLE_W'(($urandom_range(0, 3) == 0) ? lo : $urandom_range(4095, lo));
      end
      -1: begin
        hi = c - d - 1;
        if (hi < 0) begin
          return SAMPLE_W'($urandom);
        end
        return SAMPLE_W'(($urandom_range(0, 3) == 0) ? hi : $urandom_range(hi, 0));
      end
      default: begin
        lo = (c - d < 0) ? 0 : c - d;
        hi = (c + d > 4095) ? 4095 : c + d;
        if ($urandom_range(0, 3) == 0) begin
          return SAMPLE_W'($urandom_range(0, 1) ? lo : hi);
        end
        return SAMPLE_W'($urandom_range(hi, lo));
      end
    endcase
  endfunction

  // tick moves mostly in small steps, sometimes jumps anywhere or wraps
  task automatic advance_time();
    int r;
    r = $urandom_range(0, 31);
    if (r == 0) begin
      now_ms = $urandom;
    end else if (r == 1) begin
      now_ms = now_ms + 32'hFFFF_FFFF - $urandom_range(0, 3);
    end else begin
      now_ms = now_ms + $urandom_range(0, int'(debounce_len) / 8 + 4);
    end
  endtask

  // held level with occasional one-frame bounces
  function automatic logic next_button();
    if ($urandom_range(0, 7) == 0) begin
      btn_target = !btn_target;
    end
    return ($urandom_range(0, 5) == 0) ? !btn_target : btn_target;
  endfunction

  // mostly held stick positions long enough to confirm, plus noise bursts
  task automatic play_gestures(int frames);
    int sent;
    int side_x;
    int side_y;
    int len;
    bit noise;
    logic [SAMPLE_W-1:0] xs;
    logic [SAMPLE_W-1:0] ys;
    sent = 0;
    while (sent < frames) begin
      noise  = ($urandom_range(0, 9) >= 8);
      side_x = int'($urandom_range(0, 2)) - 1;
      side_y = int'($urandom_range(0, 2)) - 1;
      len    = noise ? $urandom_range(1, 6) : $urandom_range(1, int'(confirm_need) + 3);
      for (int i = 0; i < len && sent < frames; i++) begin
        if (noise || $urandom_range(0, 11) == 0) begin
          xs = SAMPLE_W'($urandom);
          ys = SAMPLE_W'($urandom);
        end else begin
          xs = pick_sample(ctr_x, side_x);
          // y is inverted: a positive reading needs a sample below centre
          ys = pick_sample(ctr_y, -side_y);
        end
        advance_time();
        send_frame(xs, ys, next_button(), now_ms);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset settings; sample and tick extremes, confirm after three reads,
  // immediate return to zero
  task automatic test_field_extremes();
    send_frame(12'd2048, 12'd2048, 1'b0, 32'd0);
    send_frame(12'd4095, 12'd0, 1'b1, 32'd100);
    send_frame(12'd4095, 12'd0, 1'b1, 32'd101);
    send_frame(12'd4095, 12'd0, 1'b1, 32'd102);
    send_frame(12'd0, 12'd4095, 1'b0, 32'hFFFF_FFFF);
    send_frame(12'd2048, 12'd2048, 1'b0, 32'hFFFF_FFFF);
  endtask

  // single read confirm; diagonals keep the last heading
  task automatic test_diagonal_memory();
    set_registers(12'd2048, 12'd2048, 12'd650, 4'd1, 16'd35);
    send_frame(12'd4095, 12'd2048, 1'b0, 32'd10);
    send_frame(12'd4095, 12'd0, 1'b0, 32'd11);
    send_frame(12'd2048, 12'd2048, 1'b0, 32'd12);
    send_frame(12'd2048, 12'd0, 1'b0, 32'd13);
    send_frame(12'd4095, 12'd0, 1'b0, 32'd14);
    send_frame(12'd0, 12'd4095, 1'b0, 32'd15);
  endtask

  // zero confirm reads accepts at once, fifteen needs a long run
  task automatic test_confirm_extremes();
    set_registers(12'd2048, 12'd2048, 12'd650, 4'd0, 16'd35);
    send_frame(12'd0, 12'd2048, 1'b0, 32'd20);
    send_frame(12'd2048, 12'd2048, 1'b0, 32'd21);
    set_registers(12'd2048, 12'd2048, 12'd650, 4'd15, 16'd35);
    send_frame(12'd0, 12'd0, 1'b0, 32'd22);
    send_frame(12'd0, 12'd0, 1'b0, 32'd23);
  endtask

  // zero debounce takes every change; full debounce across the tick wrap,
  // one ms short and then exactly on time
  task automatic test_debounce_edges();
    set_registers(12'd2048, 12'd2048, 12'd650, 4'd3, 16'd0);
    send_frame(12'd2048, 12'd2048, 1'b1, 32'd500);
    send_frame(12'd2048, 12'd2048, 1'b0, 32'd500);
    send_frame(12'd2048, 12'd2048, 1'b1, 32'd500);
    set_registers(12'd2048, 12'd2048, 12'd650, 4'd3, 16'hFFFF);
    send_frame(12'd2048, 12'd2048, 1'b0, 32'hFFFF_FFF0);
    send_frame(12'd2048, 12'd2048, 1'b1, 32'h0000_FFEE);
    send_frame(12'd2048, 12'd2048, 1'b1, 32'h0000_FFEF);
  endtask

  // writes to indexes past the last register change nothing
  task automatic test_unused_index();
    settle();
    for (int i = int'(CFG_DEBOUNCE_MS) + 1; i < 8; i++) begin
      write_reg(i[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
    end
    send_frame(12'd4095, 12'd2048, 1'b0, 32'h0002_0000);
    send_frame(12'd2048, 12'd4095, 1'b0, 32'h0002_0001);
  endtask

  // receiver holds off long enough that the pipe fills and in_ready drops
  task automatic test_backpressure();
    set_registers(12'd2048, 12'd2048, 12'd650, 4'd3, 16'd35);
    input_gaps = 1'b0;
    rx_stalls  = 1'b0;
    @(posedge clk);
    rx_hold_left = LONG_HOLD;
    play_gestures(60);
    settle();
  endtask

  // random frames over several settings, extremes among them, with the
  // sender gaps and receiver stalls switched on and off between phases
  task automatic test_random_settings();
    now_ms = 32'h0003_0000;
    input_gaps = 1'b1;
    rx_stalls  = 1'b1;
    set_registers(CENTER_RST, CENTER_RST, DEADZONE_RST, CONFIRM_RST, DEBOUNCE_RST);
    play_gestures(400);
    // zero deadzone, centres at the rails, fastest confirm and debounce
    rx_stalls = 1'b0;
    set_registers(12'd0, 12'd4095, 12'd0, 4'd1, 16'd0);
    play_gestures(200);
    // widest deadzone: nothing can deflect
    input_gaps = 1'b0;
    rx_stalls  = 1'b1;
    set_registers(12'd4095, 12'd0, 12'd4095, 4'd15, 16'hFFFF);
    play_gestures(200);
    for (int p = 0; p < 4; p++) begin
      input_gaps = (p != 1);
      rx_stalls  = (p != 2);
      set_registers(SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                    SAMPLE_W'($urandom_range(0, 1200)),
                    COUNT_W'($urandom_range(1, 15)),
                    DEBOUNCE_W'($urandom_range(0, 200)));
      play_gestures(250);
    end
    input_gaps = 1'b1;
    rx_stalls  = 1'b1;
    set_registers(12'd1000, 12'd3000, 12'd300, 4'd0, 16'd1);
    play_gestures(150);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_x_sample     = '0;
    in_y_sample     = '0;
    in_button_level = 1'b0;
    in_time_ms      = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    error_count     = 0;
    results_seen    = 0;
    now_ms          = '0;
    btn_target      = 1'b0;
    input_gaps      = 1'b1;
    burst_left      = 0;
    rx_stalls       = 1'b1;
    rx_hold_left    = 0;
    reset_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_diagonal_memory();
    test_confirm_extremes();
    test_debounce_edges();
    test_unused_index();
    test_backpressure();
    test_random_settings();

    settle();
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_joystick_button_qualifier: clean");
    end else begin
      $display("tb_joystick_button_qualifier: errors");
    end
    $finish;
  end

endmodule
